[design/brrt_pkg.sv]
// package for the byte range reassembly tracker
// holds the sequencer state type, outcome codes and the modular compare
// no dependencies
package brrt_pkg;

    localparam int MAX_RANGES_DEF = 32;

    // outcome codes
    localparam logic [1:0] OUT_STORED = 2'd0;
    localparam logic [1:0] OUT_DUP    = 2'd1;
    localparam logic [1:0] OUT_REJECT = 2'd2;
    localparam logic [1:0] OUT_OVF    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_PUT,
        S_CPRD,
        S_CPWR,
        S_DONE
    } t_state;

    // x is before y modulo 2^32
    function automatic logic f_before(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] d;
        d = x - y;
        return d[31];
    endfunction

endpackage

[design/byte_range_reassembly_tracker.sv]
// top level of the byte range reassembly tracker
// sequencer, range memory and spill memory in one module
// depends on brrt_pkg
//
// Usage: segments [seg_start, seg_end) enter on the input channel (i_valid /
// o_ready); one result word per segment leaves on the output channel
// (o_valid / i_ready). The configuration channel (i_cfg_valid / o_cfg_ready)
// writes message_length, which empties the range list and reloads the
// remaining byte count; it is taken only while the sequencer is idle and no
// segment is offered on the input channel.
// A rejected or overflowing segment goes straight to its result.
// Otherwise the sequencer reads the stored ranges from the last one down,
// with a memory read, then a compare/update, for each range visited, then
// writes the new range and moves every kept range above it back from the
// spill memory, one read and one write per range moved, before the result
// word is loaded; o_ready is low during that work.
// Reset (synchronous, active low) clears the list and the remaining count
// to zero. A finished result sits in an output register; the next segment
// is accepted while it waits, but its own result holds the sequencer in
// its last state until the receiver takes the earlier word.
module byte_range_reassembly_tracker #(
    parameter int MAX_RANGES = brrt_pkg::MAX_RANGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_message_length,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_seg_start,
    input  logic [31:0] i_seg_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_complete,
    output logic [1:0]  o_outcome,
    output logic [31:0] o_remaining_bytes
);
    import brrt_pkg::*;

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_tcnt, n_tcnt;
    logic [CW-1:0] r_p, n_p;
    logic [CW-1:0] r_w, n_w;
    logic          r_ins, n_ins;
    logic [31:0]   r_s, n_s;
    logic [31:0]   r_e, n_e;
    logic [31:0]   r_rem, n_rem;
    logic [1:0]    r_res, n_res;

    logic          r_out_valid;
    logic          r_out_complete;
    logic [1:0]    r_out_outcome;
    logic [31:0]   r_out_rem;

    // range memory and spill memory, {start, end}
    logic [63:0]   r_mem [MAX_RANGES];
    logic [63:0]   r_tmp [MAX_RANGES];
    logic [63:0]   r_mem_rd;
    logic [63:0]   r_tmp_rd;
    logic [AW-1:0] mem_raddr, mem_waddr, tmp_raddr, tmp_waddr;
    logic [63:0]   mem_wdata, tmp_wdata;
    logic          mem_we, tmp_we;

    logic [31:0]   a, b;
    logic          in_acc, cfg_acc, out_load;

    assign a = r_mem_rd[63:32];
    assign b = r_mem_rd[31:0];

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign o_valid           = r_out_valid;
    assign o_complete        = r_out_complete;
    assign o_outcome         = r_out_outcome;
    assign o_remaining_bytes = r_out_rem;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_rem == 32'd0 || i_seg_start == i_seg_end || r_count >= MAXC) begin
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_EVAL;
            S_EVAL: begin
                if (f_before(b, r_e)) begin
                    if (!f_before(a, r_s)) begin
                        n_state = (r_idx == '0) ? S_PUT : S_RD;
                    end else begin
                        n_state = S_PUT;
                    end
                end else if (!f_before(r_s, a)) begin
                    n_state = S_PUT;
                end else begin
                    n_state = (r_idx == '0) ? S_PUT : S_RD;
                end
            end
            S_PUT:  n_state = (r_tcnt == '0) ? S_DONE : S_CPRD;
            S_CPRD: n_state = S_CPWR;
            S_CPWR: n_state = (r_tcnt == '0) ? S_DONE : S_CPRD;
            S_DONE: n_state = out_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_tcnt    = r_tcnt;
        n_p       = r_p;
        n_w       = r_w;
        n_ins     = r_ins;
        n_s       = r_s;
        n_e       = r_e;
        n_rem     = r_rem;
        n_res     = r_res;
        mem_we    = 1'b0;
        tmp_we    = 1'b0;
        mem_waddr = r_w[AW-1:0];
        mem_wdata = r_tmp_rd;
        tmp_waddr = r_tcnt[AW-1:0];
        tmp_wdata = r_mem_rd;
        mem_raddr = AW'(r_idx - ONE);
        tmp_raddr = AW'(r_tcnt - ONE);
        case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_count = '0;
                    n_rem   = i_cfg_message_length;
                end
                if (in_acc) begin
                    n_s    = i_seg_start;
                    n_e    = i_seg_end;
                    n_idx  = r_count;
                    n_tcnt = '0;
                    n_p    = '0;
                    n_ins  = 1'b1;
                    if (r_rem == 32'd0 || i_seg_start == i_seg_end) begin
                        n_res = OUT_REJECT;
                    end else if (r_count >= MAXC) begin
                        n_res = OUT_OVF;
                    end else begin
                        n_res = OUT_STORED;
                    end
                end
            end
            S_RD: begin
                n_idx = r_idx - ONE;
            end
            S_EVAL: begin
                if (f_before(b, r_e)) begin
                    if (!f_before(a, r_s)) begin
                        // covered range is removed
                        n_rem = r_rem + (b - a);
                    end else begin
                        // segment front trimmed to range end
                        if (f_before(r_s, b)) begin
                            n_s = b;
                        end
                        n_p   = r_idx + ONE;
                        n_ins = 1'b1;
                    end
                end else if (!f_before(r_s, a)) begin
                    // segment lies inside this range
                    n_p   = r_idx + ONE;
                    n_ins = 1'b0;
                    n_res = OUT_DUP;
                end else begin
                    tmp_we = 1'b1;
                    n_tcnt = r_tcnt + ONE;
                    if (f_before(a, r_e)) begin
                        n_rem = r_rem + (r_e - a);
                        if (r_e == b) begin
                            tmp_we = 1'b0;
                            n_tcnt = r_tcnt;
                        end else begin
                            tmp_wdata = {r_e, b};
                        end
                    end
                end
            end
            S_PUT: begin
                mem_waddr = r_p[AW-1:0];
                mem_wdata = {r_s, r_e};
                mem_we    = r_ins;
                if (r_ins) begin
                    n_rem = r_rem - (r_e - r_s);
                end
                n_w     = r_p + (r_ins ? ONE : '0);
                n_count = r_p + (r_ins ? ONE : '0) + r_tcnt;
            end
            S_CPRD: begin
                n_tcnt = r_tcnt - ONE;
            end
            S_CPWR: begin
                mem_we = 1'b1;
                n_w    = r_w + ONE;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (tmp_we) begin
            r_tmp[tmp_waddr] <= tmp_wdata;
        end
        r_mem_rd <= r_mem[mem_raddr];
        r_tmp_rd <= r_tmp[tmp_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rem   <= n_rem;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and result word registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_tcnt <= n_tcnt;
        r_p    <= n_p;
        r_w    <= n_w;
        r_ins  <= n_ins;
        r_s    <= n_s;
        r_e    <= n_e;
        r_res  <= n_res;
        if (out_load) begin
            r_out_complete <= (r_rem == 32'd0);
            r_out_outcome  <= r_res;
            r_out_rem      <= r_rem;
        end
    end

endmodule

[verif/byte_range_reassembly_tracker_tb.sv]
// testbench for the byte range reassembly tracker
// directed and random segment streams checked against a built-in range-list predictor
// depends on brrt_pkg and byte_range_reassembly_tracker
module byte_range_reassembly_tracker_tb;
    import brrt_pkg::*;

    localparam int NRANGE = 32;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        complete;
        logic [1:0]  outcome;
        logic [31:0] remaining;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_message_length;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_seg_start;
    logic [31:0] i_seg_end;
    logic        o_valid;
    logic        i_ready;
    logic        o_complete;
    logic [1:0]  o_outcome;
    logic [31:0] o_remaining_bytes;

    // predictor state: sorted range list and missing byte count
    logic [31:0] held_start [NRANGE];
    logic [31:0] held_end [NRANGE];
    int          held_count;
    logic [31:0] bytes_missing;

    t_result     pending_results[$];
    int          fail_count;
    int          idle_cycles;
    bit          calm;

    byte_range_reassembly_tracker dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit seq_lt(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] d;
        d = x - y;
        return d[31];
    endfunction

    function automatic void remove_range(input int idx);
        for (int k = idx; k + 1 < held_count; k++) begin
            held_start[k] = held_start[k + 1];
            held_end[k] = held_end[k + 1];
        end
        held_count--;
    endfunction

    function automatic void insert_range(input int pos, input logic [31:0] s,
                                         input logic [31:0] e);
        for (int k = held_count; k > pos; k--) begin
            held_start[k] = held_start[k - 1];
            held_end[k] = held_end[k - 1];
        end
        held_start[pos] = s;
        held_end[pos] = e;
        held_count++;
    endfunction

    // merge one segment into the range list and give the expected word
    function automatic t_result merge_segment(input logic [31:0] s_in,
                                              input logic [31:0] e);
        t_result     r;
        logic [31:0] s;
        logic [31:0] a;
        logic [31:0] b;
        int          i;
        bit          placed;
        bit          dup;
        s = s_in;
        placed = 0;
        dup = 0;
        r.outcome = OUT_STORED;
        if (bytes_missing == 0 || s == e) begin
            r.outcome = OUT_REJECT;
        end else if (held_count >= NRANGE) begin
            r.outcome = OUT_OVF;
        end else begin
            i = held_count;
            while (i > 0) begin
                i--;
                a = held_start[i];
                b = held_end[i];
                if (seq_lt(b, e)) begin
                    // stored range ends first: covered, or trims our front
                    if (!seq_lt(a, s)) begin
                        bytes_missing += b - a;
                        remove_range(i);
                        continue;
                    end
                    if (seq_lt(s, b)) s = b;
                    insert_range(i + 1, s, e);
                    bytes_missing -= e - s;
                    placed = 1;
                    break;
                end
                if (!seq_lt(s, a)) begin
                    dup = 1;
                    break;
                end
                // we overlap the stored range front
                if (seq_lt(a, e)) begin
                    bytes_missing += e - a;
                    if (e == b) remove_range(i);
                    else held_start[i] = e;
                end
            end
            if (dup) begin
                r.outcome = OUT_DUP;
            end else if (!placed) begin
                insert_range(0, s, e);
                bytes_missing -= e - s;
            end
        end
        r.complete = (bytes_missing == 0);
        r.remaining = bytes_missing;
        return r;
    endfunction

    // accept segments, check result words, watchdog
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                pending_results.push_back(merge_segment(i_seg_start, i_seg_end));
            if (o_valid && i_ready) begin
                got = '{o_complete, o_outcome, o_remaining_bytes};
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.complete !== want.complete) begin
                        $error("complete: expected %0d actual %0d", want.complete,
                               got.complete);
                        fail_count++;
                    end
                    if (got.outcome !== want.outcome) begin
                        $error("outcome: expected %0d actual %0d", want.outcome,
                               got.outcome);
                        fail_count++;
                    end
                    if (got.remaining !== want.remaining) begin
                        $error("remaining_bytes: expected %0h actual %0h",
                               want.remaining, got.remaining);
                        fail_count++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("byte_range_reassembly_tracker: mismatch");
                $finish;
            end
        end
    end

    // receiver stalls in random bursts
    initial begin
        int stall;
        stall = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall == 0 && !calm && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 6);
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // one segment word, sometimes after a sender gap; valid stays high after
    task automatic send_segment(input logic [31:0] s, input logic [31:0] e);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_seg_start <= s;
        i_seg_end <= e;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // message length write while idle; predictor follows
    task automatic set_length(input logic [31:0] len);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_message_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        held_count = 0;
        bytes_missing = len;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_after_reset();
        send_segment(32'd0, 32'd10);
        send_segment(32'hFFFF_FFFF, 32'd0);
        set_length(32'd0);
        send_segment(32'd5, 32'd6);
    endtask

    // overlap, trim, duplicate, cover-all, empty, wrap across zero
    task automatic test_overlaps();
        logic [31:0] b;
        b = 32'hFFFF_FFE0;
        set_length(32'd100);
        send_segment(b + 10, b + 20);
        send_segment(b + 15, b + 30);
        send_segment(b + 5, b + 12);
        send_segment(b + 12, b + 18);
        send_segment(b + 50, b + 60);
        send_segment(b + 55, b + 60);
        send_segment(b + 0, b + 40);
        send_segment(b + 70, b + 70);
        send_segment(b + 40, b + 100);
    endtask

    // completion then rejection of late segments
    task automatic test_complete();
        set_length(32'd10);
        send_segment(32'd0, 32'd10);
        send_segment(32'd0, 32'd5);
        send_segment(32'd3, 32'd3);
    endtask

    // fill the list to its depth, then overflow
    task automatic test_overflow();
        set_length(32'hFFFF_FFFF);
        for (int k = 0; k < NRANGE; k++)
            send_segment(32'(2 * k), 32'(2 * k + 1));
        send_segment(32'd100, 32'd101);
        send_segment(32'd0, 32'd1);
        send_segment(32'd0, 32'd200);
    endtask

    // random phases of segments placed around the message, plus noise
    task automatic test_random();
        logic [31:0] base;
        logic [31:0] len;
        logic [31:0] s;
        int          mode;
        for (int ph = 0; ph < 10; ph++) begin
            calm = (ph == 9);
            mode = $urandom_range(0, 3);
            base = $urandom;
            case (mode)
                0: len = $urandom_range(1, 64);
                1: len = 32'd200;
                2: len = $urandom_range(1, 5000);
                default: len = (ph % 2) ? 32'hFFFF_FFFF : $urandom;
            endcase
            set_length(len);
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_segment($urandom, $urandom);
                end else if (mode == 1) begin
                    s = base + 2 * $urandom_range(0, 60);
                    send_segment(s, s + $urandom_range(1, 2));
                end else begin
                    s = base + $urandom_range(0, (len > 5000) ? 5000 : len);
                    send_segment(s, s + $urandom_range(0, 16));
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_message_length = '0;
        i_valid = 1'b0;
        i_seg_start = '0;
        i_seg_end = '0;
        held_count = 0;
        bytes_missing = '0;
        fail_count = 0;
        idle_cycles = 0;
        calm = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_after_reset();
        test_overlaps();
        test_complete();
        test_overflow();
        test_random();
        wait_drained();
        repeat (140) @(posedge i_clk);
        if (fail_count == 0)
            $display("byte_range_reassembly_tracker: match");
        else
            $display("byte_range_reassembly_tracker: mismatch");
        $finish;
    end

endmodule

[filelist.f]
design/brrt_pkg.sv
design/byte_range_reassembly_tracker.sv
verif/byte_range_reassembly_tracker_tb.sv
